[rtl/core/gdrc_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants and register codes of the grid ray caster
// no dependencies; used by every module under rtl/core except gdrc_ram
package gdrc_pkg;

	localparam int GRID_SIZE   = 64;
	localparam int QUEUE_DEPTH = 2;
	localparam int ANGLE_BITS  = 10;
	localparam int FRAC_BITS   = 10;
	localparam int POS_W       = 16;
	localparam int CELL_W      = 6;
	localparam int COL_W       = 10;
	localparam int DIST_W      = 17;
	localparam int COORD_W     = 10;
	localparam int OUT_COORD_W = 8;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_FOV      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCR_W    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_W   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_H   = 3'd4;

	localparam logic [8:0]  FOV_RST      = 9'd171;
	localparam logic [16:0] MAX_DIST_RST = 17'd20480;
	localparam logic [10:0] SCR_W_RST    = 11'd320;
	localparam logic [6:0]  GRID_W_RST   = 7'd64;
	localparam logic [6:0]  GRID_H_RST   = 7'd64;

	// item kinds
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_CAST  = 1'b1;

	// quarter-wave sine polynomial, q16
	localparam logic [16:0] SIN_A = 17'd102944;
	localparam logic [15:0] SIN_B = 16'd42048;
	localparam logic [12:0] SIN_C = 13'd4640;
	localparam logic [16:0] NEAR_ZERO = 17'd7;

	typedef struct packed {
		logic [8:0]  fov;
		logic [16:0] max_dist;
		logic [10:0] scr_w;
		logic [6:0]  grid_w;
		logic [6:0]  grid_h;
	} cfg_t;

	typedef struct packed {
		logic                  cmd;
		logic [CELL_W-1:0]     cell_x;
		logic [CELL_W-1:0]     cell_y;
		logic                  is_wall;
		logic [POS_W-1:0]      pos_x;
		logic [POS_W-1:0]      pos_y;
		logic [ANGLE_BITS-1:0] view;
		logic [ANGLE_BITS-1:0] ray;
	} item_t;

	typedef struct packed {
		logic                   hit;
		logic [DIST_W-1:0]      distance;
		logic [OUT_COORD_W-1:0] last_cell_x;
		logic [OUT_COORD_W-1:0] last_cell_y;
		logic                   side;
	} result_t;

endpackage

[rtl/core/gdrc_ram.sv]
`timescale 1ns / 1ps
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module gdrc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/gdrc_queue.sv]
`timescale 1ns / 1ps
// short request queue between the front and the back of the ray caster
// depends on gdrc_pkg
module gdrc_queue #(
	parameter int DEPTH = gdrc_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  gdrc_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output gdrc_pkg::item_t pop_item,
	output logic            empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	gdrc_pkg::item_t entry_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;

	assign full     = (count_q == CW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_item = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_item;
		end
	end

endmodule

[rtl/core/gdrc_front.sv]
`timescale 1ns / 1ps
// front of the ray caster: takes requests, drops off-screen casts and works out the ray angle
// depends on gdrc_pkg
module gdrc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  gdrc_pkg::cfg_t  cfg,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  logic [71:0]     s_tdata,
	input  logic            s_tuser,
	output logic            push,
	output gdrc_pkg::item_t push_item,
	input  logic            q_full
);

	localparam logic [2:0] F_IDLE = 3'd0;
	localparam logic [2:0] F_MUL  = 3'd1;
	localparam logic [2:0] F_SUM  = 3'd2;
	localparam logic [2:0] F_DIV  = 3'd3;
	localparam logic [2:0] F_PUSH = 3'd4;
	localparam int NUM_W = 24;

	logic [2:0] state_q;
	gdrc_pkg::item_t in_item, item_q;
	logic [gdrc_pkg::COL_W-1:0] col_in, col_q;
	logic accept, cast_ok;
	logic [22:0] a_q;
	logic [19:0] b_q, c_q;
	logic [NUM_W-1:0] num_q, num_nx;
	logic [11:0] rem_q, rem_nx, w2;
	logic [12:0] rem_sh;
	logic ge;
	logic [4:0] cnt_q;
	logic [10:0] view_p1;

	always_comb begin
		in_item         = '0;
		in_item.cmd     = s_tuser;
		in_item.cell_x  = s_tdata[5:0];
		in_item.cell_y  = s_tdata[11:6];
		in_item.is_wall = s_tdata[12];
		in_item.pos_x   = s_tdata[28:13];
		in_item.pos_y   = s_tdata[44:29];
		in_item.view    = s_tdata[54:45];
	end
	assign col_in = s_tdata[64:55];

	assign s_tready = (state_q == F_IDLE) && !q_full;
	assign accept   = s_tvalid && s_tready;
	assign cast_ok  = ({1'b0, col_in} < cfg.scr_w);

	always_comb begin
		push_item     = item_q;
		push_item.ray = num_q[gdrc_pkg::ANGLE_BITS-1:0];
		if (state_q != F_PUSH) begin
			push_item = in_item;
		end
	end
	assign push = (accept && (s_tuser == gdrc_pkg::CMD_WRITE))
		|| ((state_q == F_PUSH) && !q_full);

	// restoring divide of the angle numerator by twice the screen width
	assign w2      = {cfg.scr_w, 1'b0};
	assign rem_sh  = {rem_q, num_q[NUM_W-1]};
	assign ge      = (rem_sh >= {1'b0, w2});
	assign rem_nx  = ge ? 12'(rem_sh - {1'b0, w2}) : rem_sh[11:0];
	assign num_nx  = {num_q[NUM_W-2:0], ge};
	assign view_p1 = {1'b0, item_q.view} + 11'd1024;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept && (s_tuser == gdrc_pkg::CMD_CAST) && cast_ok) begin
						state_q <= F_MUL;
					end
				end
				F_MUL: state_q <= F_SUM;
				F_SUM: state_q <= F_DIV;
				F_DIV: begin
					if (cnt_q == 5'(NUM_W - 1)) begin
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (accept) begin
					item_q <= in_item;
					col_q  <= col_in;
				end
			end
			F_MUL: begin
				a_q <= {12'd0, view_p1} * {11'd0, w2};
				b_q <= {11'd0, cfg.fov} * {9'd0, cfg.scr_w};
				c_q <= {11'd0, cfg.fov} * {9'd0, col_q, 1'b1};
			end
			F_SUM: begin
				num_q <= {1'b0, a_q} - {4'd0, b_q} + {4'd0, c_q} + {13'd0, cfg.scr_w};
				rem_q <= '0;
				cnt_q <= '0;
			end
			F_DIV: begin
				num_q <= num_nx;
				rem_q <= rem_nx;
				cnt_q <= cnt_q + 1'b1;
			end
			default: ;
		endcase
	end

endmodule

[rtl/core/gdrc_back.sv]
`timescale 1ns / 1ps
// back of the ray caster: grid store, trig, step lengths, dda walk and distance
// depends on gdrc_pkg and gdrc_ram
module gdrc_back #(
	parameter int GRID_SIZE = gdrc_pkg::GRID_SIZE
) (
	input  logic              clk,
	input  logic              arst_n,
	input  gdrc_pkg::cfg_t    cfg,
	input  logic              q_empty,
	output logic              q_pop,
	input  gdrc_pkg::item_t   q_item,
	output logic              out_valid,
	input  logic              out_ready,
	output gdrc_pkg::result_t out_res
);

	localparam int DEPTH = GRID_SIZE * GRID_SIZE;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = gdrc_pkg::COORD_W;
	localparam int AB    = gdrc_pkg::ANGLE_BITS;
	localparam int FB    = gdrc_pkg::FRAC_BITS;
	localparam int MW    = gdrc_pkg::POS_W - FB;
	localparam logic [AB-1:0] QUARTER = AB'(1 << (AB - 2));
	localparam logic [10:0] FRAC_ONE = 11'(1 << FB);

	localparam logic [3:0] B_CLR   = 4'd0;
	localparam logic [3:0] B_IDLE  = 4'd1;
	localparam logic [3:0] B_TRIG  = 4'd2;
	localparam logic [3:0] B_RSET  = 4'd3;
	localparam logic [3:0] B_RDIV  = 4'd4;
	localparam logic [3:0] B_SIDE0 = 4'd5;
	localparam logic [3:0] B_SIDE1 = 4'd6;
	localparam logic [3:0] B_WSTEP = 4'd7;
	localparam logic [3:0] B_WCHK  = 4'd8;
	localparam logic [3:0] B_RAW   = 4'd9;
	localparam logic [3:0] B_DIST  = 4'd10;
	localparam logic [3:0] B_OUT   = 4'd11;

	function automatic logic [AW-1:0] cell_addr(input logic [8:0] x, input logic [8:0] y);
		cell_addr = AW'(32'(y) * GRID_SIZE + 32'(x));
	endfunction

	logic [3:0] state_q;
	logic [AW-1:0] clr_q;
	gdrc_pkg::item_t item_q;
	logic [1:0] tsel_q;
	logic [2:0] tstep_q;
	logic [16:0] z2_q, cmag_q, smag_q, kmag_q;
	logic cneg_q, sneg_q, kneg_q;
	logic ax_q;
	logic [16:0] rem_q, rem_nx;
	logic [17:0] rem_sh;
	logic [23:0] quot_q, quot_nx, dx_q, dy_q;
	logic [4:0] cnt_q;
	logic [31:0] sdx_q, sdy_q, raw;
	logic infx_q, infy_q, negx_q, negy_q;
	logic signed [CW-1:0] mx_q, my_q, nmx, nmy;
	logic side_q, hit_q;
	logic [gdrc_pkg::DIST_W-1:0] dist_q, lim;
	logic [55:0] prod_q;
	logic [31:0] mul_a;
	logic [23:0] mul_b;
	logic out_valid_q;
	gdrc_pkg::result_t out_q;

	logic [AB-1:0] ang;
	logic [8:0] rr;
	logic [16:0] z, phi, dmag;
	logic dneg, dinf, rge;
	logic [gdrc_pkg::POS_W-1:0] pos;
	logic [10:0] frac;
	logic step_x, in_grid, cr_pos;
	logic [8:0] gw, gh;
	logic [39:0] dprod;
	logic ram_we, ram_wdata, ram_rdata, cell_ok;
	logic [AW-1:0] ram_waddr, ram_raddr;

	// one sine of the quarter-wave polynomial per trig slot: cos ray, sin ray, cos correction
	always_comb begin
		case (tsel_q)
			2'd0:    ang = item_q.ray + QUARTER;
			2'd1:    ang = item_q.ray;
			default: ang = item_q.ray - item_q.view + QUARTER;
		endcase
	end
	assign rr  = ang[AB-2] ? 9'(QUARTER) - 9'(ang[AB-3:0]) : 9'(ang[AB-3:0]);
	assign z   = 17'(rr) << (18 - AB);
	assign phi = prod_q[32:16];

	// reciprocal of one direction magnitude
	assign dmag    = ax_q ? smag_q : cmag_q;
	assign dneg    = ax_q ? sneg_q : cneg_q;
	assign dinf    = (dmag < gdrc_pkg::NEAR_ZERO);
	assign rem_sh  = {rem_q, (cnt_q == 5'd0)};
	assign rge     = (rem_sh >= {1'b0, dmag});
	assign rem_nx  = rge ? 17'(rem_sh - {1'b0, dmag}) : rem_sh[16:0];
	assign quot_nx = {quot_q[22:0], rge};
	assign pos     = ax_q ? item_q.pos_y : item_q.pos_x;
	assign frac    = dneg ? 11'(pos[FB-1:0]) : FRAC_ONE - 11'(pos[FB-1:0]);

	// walk step
	assign step_x  = infx_q ? 1'b0 : (infy_q ? 1'b1 : (sdx_q < sdy_q));
	assign nmx     = step_x ? (negx_q ? mx_q - 1'b1 : mx_q + 1'b1) : mx_q;
	assign nmy     = step_x ? my_q : (negy_q ? my_q - 1'b1 : my_q + 1'b1);
	assign gw      = (32'(cfg.grid_w) > GRID_SIZE) ? 9'(GRID_SIZE) : 9'(cfg.grid_w);
	assign gh      = (32'(cfg.grid_h) > GRID_SIZE) ? 9'(GRID_SIZE) : 9'(cfg.grid_h);
	assign in_grid = !mx_q[CW-1] && !my_q[CW-1]
		&& (mx_q[8:0] < gw) && (my_q[8:0] < gh);

	assign raw    = side_q ? sdy_q - {8'd0, dy_q} : sdx_q - {8'd0, dx_q};
	assign cr_pos = !kneg_q && (kmag_q != '0);
	assign dprod  = prod_q[55:16];
	assign lim    = (cfg.max_dist == '0) ? 17'd1 : cfg.max_dist;

	// shared multiplier, product registered every cycle
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			B_TRIG: begin
				case (tstep_q)
					3'd0: begin
						mul_a = 32'(z);
						mul_b = 24'(z);
					end
					3'd1: begin
						mul_a = 32'(gdrc_pkg::SIN_C);
						mul_b = 24'(phi);
					end
					3'd2: begin
						mul_a = 32'(17'(gdrc_pkg::SIN_B) - phi);
						mul_b = 24'(z2_q);
					end
					3'd3: begin
						mul_a = 32'(gdrc_pkg::SIN_A - phi);
						mul_b = 24'(z);
					end
					default: ;
				endcase
			end
			B_SIDE0: begin
				mul_a = 32'(frac);
				mul_b = ax_q ? dy_q : dx_q;
			end
			B_RAW: begin
				mul_a = raw;
				mul_b = 24'(kmag_q);
			end
			default: ;
		endcase
	end

	// grid store: clearing pass, cell writes and walk reads
	assign cell_ok   = (32'(q_item.cell_x) < GRID_SIZE) && (32'(q_item.cell_y) < GRID_SIZE);
	assign q_pop     = (state_q == B_IDLE) && !q_empty;
	assign ram_we    = (state_q == B_CLR)
		|| (q_pop && (q_item.cmd == gdrc_pkg::CMD_WRITE) && cell_ok);
	assign ram_waddr = (state_q == B_CLR) ? clr_q
		: cell_addr(9'(q_item.cell_x), 9'(q_item.cell_y));
	assign ram_wdata = (state_q == B_CLR) ? 1'b0 : q_item.is_wall;
	assign ram_raddr = cell_addr(nmx[8:0], nmy[8:0]);

	gdrc_ram #(
		.WIDTH(1),
		.DEPTH(DEPTH)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == B_OUT) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (q_pop && (q_item.cmd == gdrc_pkg::CMD_CAST)) begin
						state_q <= B_TRIG;
					end
				end
				B_TRIG: begin
					if ((tstep_q == 3'd4) && (tsel_q == 2'd2)) begin
						state_q <= B_RSET;
					end
				end
				B_RSET: state_q <= B_RDIV;
				B_RDIV: begin
					if (cnt_q == 5'd26) begin
						state_q <= B_SIDE0;
					end
				end
				B_SIDE0: state_q <= B_SIDE1;
				B_SIDE1: state_q <= ax_q ? B_WSTEP : B_RSET;
				B_WSTEP: state_q <= B_WCHK;
				B_WCHK: begin
					if (!in_grid) begin
						state_q <= B_OUT;
					end else if (ram_rdata) begin
						state_q <= B_RAW;
					end else begin
						state_q <= B_WSTEP;
					end
				end
				B_RAW:  state_q <= B_DIST;
				B_DIST: state_q <= B_OUT;
				B_OUT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= {24'd0, mul_a} * {32'd0, mul_b};
		case (state_q)
			B_IDLE: begin
				item_q  <= q_item;
				tsel_q  <= '0;
				tstep_q <= '0;
				ax_q    <= 1'b0;
			end
			B_TRIG: begin
				tstep_q <= tstep_q + 1'b1;
				if (tstep_q == 3'd1) begin
					z2_q <= phi;
				end
				if (tstep_q == 3'd4) begin
					tstep_q <= '0;
					tsel_q  <= tsel_q + 1'b1;
					case (tsel_q)
						2'd0: begin
							cmag_q <= phi;
							cneg_q <= ang[AB-1] && (phi != '0);
						end
						2'd1: begin
							smag_q <= phi;
							sneg_q <= ang[AB-1] && (phi != '0);
						end
						default: begin
							kmag_q <= phi;
							kneg_q <= ang[AB-1] && (phi != '0);
						end
					endcase
				end
			end
			B_RSET: begin
				rem_q  <= '0;
				quot_q <= '0;
				cnt_q  <= '0;
			end
			B_RDIV: begin
				rem_q  <= rem_nx;
				quot_q <= quot_nx;
				cnt_q  <= cnt_q + 1'b1;
				if (cnt_q == 5'd26) begin
					if (ax_q) begin
						dy_q   <= dinf ? '0 : quot_nx;
						infy_q <= dinf;
						negy_q <= dneg;
					end else begin
						dx_q   <= dinf ? '0 : quot_nx;
						infx_q <= dinf;
						negx_q <= dneg;
					end
				end
			end
			B_SIDE1: begin
				if (ax_q) begin
					sdy_q <= prod_q[FB+31:FB];
					mx_q  <= CW'(item_q.pos_x[gdrc_pkg::POS_W-1:FB]);
					my_q  <= CW'(item_q.pos_y[gdrc_pkg::POS_W-1:FB]);
				end else begin
					sdx_q <= prod_q[FB+31:FB];
					ax_q  <= 1'b1;
				end
			end
			B_WSTEP: begin
				mx_q   <= nmx;
				my_q   <= nmy;
				side_q <= !step_x;
				if (step_x) begin
					sdx_q <= sdx_q + {8'd0, dx_q};
				end else begin
					sdy_q <= sdy_q + {8'd0, dy_q};
				end
			end
			B_WCHK: begin
				hit_q  <= in_grid;
				dist_q <= lim;
			end
			B_DIST: begin
				if (!cr_pos || (dprod == '0)) begin
					dist_q <= 17'd1;
				end else if (dprod > 40'(lim)) begin
					dist_q <= lim;
				end else begin
					dist_q <= dprod[16:0];
				end
			end
			B_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_q.hit         <= hit_q;
					out_q.distance    <= dist_q;
					out_q.last_cell_x <= mx_q[7:0];
					out_q.last_cell_y <= my_q[7:0];
					out_q.side        <= side_q;
				end
			end
			default: ;
		endcase
	end

endmodule

[rtl/core/grid_dda_ray_caster_unit.sv]
`timescale 1ns / 1ps
// top level of the grid ray caster: configuration registers, front, queue, back
// depends on gdrc_pkg, gdrc_front, gdrc_queue, gdrc_back
//
// usage
// - s_* carries requests: tuser 0 writes one grid cell, tuser 1 casts one column ray
// - m_* returns one result per cast whose column lies below screen_width;
//   writes and off-screen casts return nothing
// - cfg_* writes the five view and grid registers; write only while idle
// - a cast passes through the front (multiply, sum, 24-step divide for the ray
//   angle), then in the back through trig on the shared multiplier, two 27-step
//   reciprocal divides plus side setup, a step and a check state per grid cell
//   walked, then the distance
// - sustained rate is set by the back and falls as more cells are walked per cast;
//   a cell write is handled in the idle state of each part
// - after reset the back clears the 4096-cell grid store one cell a cycle;
//   requests queue up meanwhile (front and queue fill, then s_tready drops)
// - results sit in an output register: a stalled m_tready holds the back at its
//   last step, while the front and the queue keep taking requests until the queue fills
module grid_dda_ray_caster_unit #(
	parameter int GRID_SIZE   = gdrc_pkg::GRID_SIZE,
	parameter int QUEUE_DEPTH = gdrc_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// cell_x[5:0] cell_y[11:6] is_wall[12] pos_x[28:13] pos_y[44:29]
	// view_angle[54:45] column[64:55], zero fill above
	input  logic [71:0] s_tdata,
	// command
	input  logic [0:0]  s_tuser,
	input  logic        s_tvalid,
	output logic        s_tready,
	// hit[0] distance[17:1] last_cell_x[25:18] last_cell_y[33:26] side[34], zero fill
	output logic [39:0] m_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [gdrc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [16:0] cfg_data
);

	gdrc_pkg::cfg_t    cfg_q;
	gdrc_pkg::item_t   push_item, pop_item;
	gdrc_pkg::result_t res;
	logic push, pop, q_full, q_empty;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fov      <= gdrc_pkg::FOV_RST;
			cfg_q.max_dist <= gdrc_pkg::MAX_DIST_RST;
			cfg_q.scr_w    <= gdrc_pkg::SCR_W_RST;
			cfg_q.grid_w   <= gdrc_pkg::GRID_W_RST;
			cfg_q.grid_h   <= gdrc_pkg::GRID_H_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				gdrc_pkg::CFG_FOV:      cfg_q.fov      <= cfg_data[8:0];
				gdrc_pkg::CFG_MAX_DIST: cfg_q.max_dist <= cfg_data;
				gdrc_pkg::CFG_SCR_W:    cfg_q.scr_w    <= cfg_data[10:0];
				gdrc_pkg::CFG_GRID_W:   cfg_q.grid_w   <= cfg_data[6:0];
				gdrc_pkg::CFG_GRID_H:   cfg_q.grid_h   <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// front: request intake, cast filtering and ray angle
	gdrc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser[0]),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_full)
	);

	// decoupling queue, keeps writes and casts in order
	gdrc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_item  (pop_item),
		.empty     (q_empty)
	);

	// back: grid store, dda walk and output register
	gdrc_back #(
		.GRID_SIZE(GRID_SIZE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_pop     (pop),
		.q_item    (pop_item),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {5'd0, res.side, res.last_cell_y, res.last_cell_x,
		res.distance, res.hit};

endmodule
